// ===== design/rbcb_pkg.sv =====
// Package for the retry backoff circuit breaker.
// Holds beat structs, codes, reset values of the registers and the backoff unit handshake.
// No dependencies.
package rbcb_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic       attempt_ok;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] wait_ms;
    logic [3:0]  retries_used;
    logic [1:0]  breaker_now;
    logic [7:0]  failures_now;
  } out_beat_t;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_OUTCOME = 3'd1,
    MODE_TICK    = 3'd2,
    MODE_RESET   = 3'd3,
    MODE_CONNECT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    V_GRANTED   = 3'd0,
    V_REJECTED  = 3'd1,
    V_RETRY     = 3'd2,
    V_DONE      = 3'd3,
    V_EXHAUSTED = 3'd4,
    V_ACK       = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    BRK_CLOSED = 2'd0,
    BRK_OPEN   = 2'd1,
    BRK_HALF   = 2'd2
  } brk_e;

  typedef enum logic [2:0] {
    REG_RETRY_LIMIT  = 3'd0,
    REG_FIRST_BO     = 3'd1,
    REG_GROWTH       = 3'd2,
    REG_BO_CAP       = 3'd3,
    REG_TRIP         = 3'd4,
    REG_RECOVERY     = 3'd5
  } reg_idx_e;

  localparam logic [3:0]  RstRetryLimit = 4'd3;
  localparam logic [15:0] RstFirstBo    = 16'd100;
  localparam logic [11:0] RstGrowth     = 12'd512;
  localparam logic [15:0] RstBoCap      = 16'd30000;
  localparam logic [7:0]  RstTrip       = 8'd5;
  localparam logic [15:0] RstRecovery   = 16'd120;

  typedef struct packed {
    logic       start;
    logic [3:0] steps;
  } bo_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] wait_ms;
  } bo_rsp_t;

endpackage

// ===== design/rbcb_backoff.sv =====
// Backoff unit: Q16.8 accumulator grown by a Q4.8 factor, capped.
// Bit-serial multiplier, one factor bit per cycle. Uses rbcb_pkg.
module rbcb_backoff (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbcb_pkg::bo_req_t req_i,
  input  logic [15:0]      first_i,
  input  logic [11:0]      growth_i,
  input  logic [15:0]      cap_i,
  output rbcb_pkg::bo_rsp_t rsp_o
);
  import rbcb_pkg::*;

  typedef enum logic [3:0] {
    BO_IDLE = 4'b0001,
    BO_MUL  = 4'b0010,
    BO_CHK  = 4'b0100,
    BO_DONE = 4'b1000
  } bo_st_e;

  bo_st_e      st_q, st_d;
  logic [23:0] acc_q, acc_d;
  logic [35:0] prod_q, prod_d;
  logic [3:0]  bit_q, bit_d;
  logic [3:0]  steps_q, steps_d;

  always_comb begin
    st_d    = st_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    bit_d   = bit_q;
    steps_d = steps_q;
    case (st_q)
      BO_IDLE: begin
        if (req_i.start) begin
          acc_d   = {first_i, 8'h00};
          prod_d  = '0;
          bit_d   = 4'd11;
          steps_d = req_i.steps;
          st_d    = (req_i.steps == 4'd0) ? BO_DONE : BO_MUL;
        end
      end
      BO_MUL: begin
        prod_d = {prod_q[34:0], 1'b0} + (growth_i[bit_q] ? {12'b0, acc_q} : 36'b0);
        if (bit_q == 4'd0) begin
          st_d = BO_CHK;
        end else begin
          bit_d = bit_q - 4'd1;
        end
      end
      BO_CHK: begin
        if (prod_q[35:8] > {4'b0, cap_i, 8'h00}) begin
          acc_d = {cap_i, 8'h00};
          st_d  = BO_DONE;
        end else begin
          acc_d = prod_q[31:8];
          if (steps_q == 4'd1) begin
            st_d = BO_DONE;
          end else begin
            steps_d = steps_q - 4'd1;
            prod_d  = '0;
            bit_d   = 4'd11;
            st_d    = BO_MUL;
          end
        end
      end
      BO_DONE: st_d = BO_IDLE;
      default: st_d = BO_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BO_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    bit_q   <= bit_d;
    steps_q <= steps_d;
  end

  assign rsp_o.done    = (st_q == BO_DONE);
  assign rsp_o.wait_ms = acc_q[23:8];

endmodule

// ===== design/retry_backoff_circuit_breaker.sv =====
// Retry guard with a closed/open/half-open circuit breaker and exponential backoff.
// Top level; uses rbcb_pkg and rbcb_backoff.
// Every event except a failed attempt with retries left gives its verdict in the cycle
// after it is taken. A retry verdict goes through the bit-serial backoff multiplier:
// one pass over the 12 factor bits plus a cap check for each earlier attempt,
// ending early once the cap is reached.
// One event is in work at a time; a finished beat waits in the output register.
module retry_backoff_circuit_breaker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rbcb_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rbcb_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import rbcb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } st_e;

  st_e         st_q;
  logic [3:0]  limit_q;
  logic [15:0] first_q;
  logic [11:0] growth_q;
  logic [15:0] cap_q;
  logic [7:0]  trip_q;
  logic [15:0] recov_q;

  brk_e        brk_q, brk_d;
  logic [7:0]  fail_q, fail_d;
  logic [15:0] ssf_q, ssf_d;
  logic [3:0]  att_q, att_d;
  logic        op_q, op_d;

  out_beat_t   out_q;
  logic        out_valid_q;
  out_beat_t   res;
  logic        is_retry;
  logic        slot_free;
  logic        accept;
  logic [7:0]  fail_1;
  logic [7:0]  fail_2;

  bo_req_t     bo_req;
  bo_rsp_t     bo_rsp;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((st_q == ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign fail_1 = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
  assign fail_2 = (fail_1 == 8'hFF) ? fail_1 : fail_1 + 8'd1;

  always_comb begin
    brk_d    = brk_q;
    fail_d   = fail_q;
    ssf_d    = ssf_q;
    att_d    = att_q;
    op_d     = op_q;
    is_retry = 1'b0;
    res      = '0;
    res.verdict = V_ACK;
    case (in_data_i.mode)
      MODE_START: begin
        if (brk_q == BRK_OPEN && ssf_q < recov_q) begin
          res.verdict = V_REJECTED;
        end else begin
          if (brk_q == BRK_OPEN) begin
            brk_d = BRK_HALF;
          end
          op_d        = 1'b1;
          att_d       = 4'd0;
          res.verdict = V_GRANTED;
        end
      end
      MODE_OUTCOME: begin
        if (op_q) begin
          if (in_data_i.attempt_ok) begin
            if (brk_q == BRK_HALF) begin
              brk_d = BRK_CLOSED;
            end
            fail_d           = 8'd0;
            res.retries_used = att_q;
            op_d             = 1'b0;
            res.verdict      = V_DONE;
          end else begin
            ssf_d = 16'd0;
            if (att_q < limit_q) begin
              fail_d      = fail_1;
              att_d       = att_q + 4'd1;
              is_retry    = 1'b1;
              res.verdict = V_RETRY;
            end else begin
              fail_d = fail_2;
              if (fail_2 >= trip_q) begin
                brk_d = BRK_OPEN;
              end
              res.retries_used = att_q;
              op_d             = 1'b0;
              res.verdict      = V_EXHAUSTED;
            end
          end
        end
      end
      MODE_TICK: begin
        if (ssf_q != 16'hFFFF) begin
          ssf_d = ssf_q + 16'd1;
        end
      end
      MODE_RESET, MODE_CONNECT: begin
        brk_d  = BRK_CLOSED;
        fail_d = 8'd0;
      end
      default: ;
    endcase
    res.breaker_now  = brk_d;
    res.failures_now = fail_d;
  end

  assign bo_req.start = accept && is_retry;
  assign bo_req.steps = att_q;

  rbcb_backoff u_backoff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (bo_req),
    .first_i  (first_q),
    .growth_i (growth_q),
    .cap_i    (cap_q),
    .rsp_o    (bo_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= RstRetryLimit;
      first_q  <= RstFirstBo;
      growth_q <= RstGrowth;
      cap_q    <= RstBoCap;
      trip_q   <= RstTrip;
      recov_q  <= RstRecovery;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RETRY_LIMIT: limit_q  <= cfg_data_i[3:0];
        REG_FIRST_BO:    first_q  <= cfg_data_i;
        REG_GROWTH:      growth_q <= cfg_data_i[11:0];
        REG_BO_CAP:      cap_q    <= cfg_data_i;
        REG_TRIP:        trip_q   <= cfg_data_i[7:0];
        REG_RECOVERY:    recov_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      brk_q       <= BRK_CLOSED;
      fail_q      <= 8'd0;
      ssf_q       <= 16'hFFFF;
      att_q       <= 4'd0;
      op_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        brk_q  <= brk_d;
        fail_q <= fail_d;
        ssf_q  <= ssf_d;
        att_q  <= att_d;
        op_q   <= op_d;
      end
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_retry) begin
              st_q        <= ST_CALC;
              out_valid_q <= out_valid_q && out_stall_i;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_CALC: begin
          if (bo_rsp.done) begin
            st_q <= ST_EMIT;
          end
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && accept && !is_retry) begin
      out_q <= res;
    end else if (st_q == ST_EMIT && slot_free) begin
      out_q.verdict      <= V_RETRY;
      out_q.wait_ms      <= bo_rsp.wait_ms;
      out_q.retries_used <= 4'd0;
      out_q.breaker_now  <= brk_q;
      out_q.failures_now <= fail_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
